// File: rtl/hmt_pkg.sv
// hmt_pkg: shared types and constants of the histogram median threshold unit
// no dependencies

package hmt_pkg;

	localparam int LEVELS     = 256;
	localparam int LEVEL_BITS = 8;
	localparam int COUNT_BITS = 23;
	localparam int RUN_BITS   = COUNT_BITS + LEVEL_BITS;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [LEVEL_BITS-1:0] LAST_LEVEL = LEVEL_BITS'(LEVELS - 1);

	typedef logic [LEVEL_BITS-1:0] level_t;
	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [RUN_BITS-1:0]   run_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_RUN,
		ST_FLUSH,
		ST_WALK,
		ST_TAIL,
		ST_DONE
	} state_t;

endpackage

// File: rtl/hmt_ram.sv
// hmt_ram: generic single-write, single-read ram with registered read data
// no dependencies

module hmt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/histogram_median_threshold_unit.sv
// histogram_median_threshold_unit: per-frame gray-level histogram and median search
// depends on hmt_pkg and hmt_ram
//
// channel   direction  handshake              payload
// pix       in         pix_valid / pix_stall  pixel, last_pixel
// res       out        res_valid / res_stall  median_level, overflow
//
// one pixel transaction per cycle while a frame streams in
// a frame's last pixel stalls the pixel channel through a flush state, a walk of the bin ram,
// a tail state and a result state that waits until the result register is free
// the walk clears each bin after reading it; the result waits in an output register
// after reset a clearing pass of the bin ram holds pix_stall high
// res_stall only holds the result register; a frame end waits if it is still full

module histogram_median_threshold_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pix_valid,
	output logic                  pix_stall,
	input  logic [7:0]            pixel,
	input  logic                  last_pixel,
	output logic                  res_valid,
	input  logic                  res_stall,
	output logic [7:0]            median_level,
	output logic                  overflow
);

	import hmt_pkg::*;

	state_t state_q, state_d;
	level_t addr_q;

	logic   pix_vld_s1;
	level_t pix_lvl_s1;
	logic   walk_vld_s1;
	level_t walk_lvl_s1;

	logic   wr_vld_q;
	level_t wr_lvl_q;
	count_t wr_val_q;

	count_t total_q;
	logic   ovf_q;
	count_t half_q;
	logic   frame_ovf_q;
	run_t   run_q;
	logic   found_q;
	level_t median_q;

	logic   res_vld_q;
	level_t res_level_q;
	logic   res_ovf_q;

	logic   ram_we;
	level_t ram_waddr;
	count_t ram_wdata;
	level_t ram_raddr;
	count_t ram_rdata;

	logic   pix_acc;
	logic   res_free;
	logic   walk_issue;
	count_t cur_cnt;
	count_t inc_cnt;
	run_t   run_sum;

	assign pix_acc  = pix_valid && !pix_stall;
	assign res_free = !res_vld_q || !res_stall;

	hmt_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(LEVELS)
	) u_bins (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// forward the bin written in the previous cycle
	assign cur_cnt = (wr_vld_q && wr_lvl_q == pix_lvl_s1) ? wr_val_q : ram_rdata;
	assign inc_cnt = (cur_cnt == COUNT_MAX) ? cur_cnt : cur_cnt + 1'b1;
	assign run_sum = run_q + RUN_BITS'(ram_rdata);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (addr_q == LAST_LEVEL) state_d = ST_RUN;
			end
			ST_RUN: begin
				if (pix_acc && last_pixel) state_d = ST_FLUSH;
			end
			ST_FLUSH: begin
				state_d = ST_WALK;
			end
			ST_WALK: begin
				if (addr_q == LAST_LEVEL) state_d = ST_TAIL;
			end
			ST_TAIL: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (res_free) state_d = ST_RUN;
			end
			default: begin
				state_d = ST_INIT;
			end
		endcase
	end

	always_comb begin
		pix_stall  = 1'b1;
		walk_issue = 1'b0;
		ram_raddr  = pixel;
		ram_we     = 1'b0;
		ram_waddr  = pix_lvl_s1;
		ram_wdata  = inc_cnt;
		case (state_q)
			ST_INIT: begin
				ram_we    = 1'b1;
				ram_waddr = addr_q;
				ram_wdata = '0;
			end
			ST_RUN: begin
				pix_stall = 1'b0;
				ram_we    = pix_vld_s1;
			end
			ST_FLUSH: begin
				ram_we = pix_vld_s1;
			end
			ST_WALK, ST_TAIL: begin
				walk_issue = (state_q == ST_WALK);
				ram_raddr  = addr_q;
				ram_we     = walk_vld_s1;
				ram_waddr  = walk_lvl_s1;
				ram_wdata  = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			addr_q      <= '0;
			pix_vld_s1  <= 1'b0;
			walk_vld_s1 <= 1'b0;
			wr_vld_q    <= 1'b0;
			total_q     <= '0;
			ovf_q       <= 1'b0;
			found_q     <= 1'b0;
			res_vld_q   <= 1'b0;
		end else begin
			state_q     <= state_d;
			pix_vld_s1  <= pix_acc;
			walk_vld_s1 <= walk_issue;
			wr_vld_q    <= (state_q == ST_RUN || state_q == ST_FLUSH) && pix_vld_s1;

			if (state_q == ST_INIT || walk_issue) begin
				addr_q <= addr_q + 1'b1;
			end

			if (pix_acc) begin
				if (total_q == COUNT_MAX) begin
					ovf_q <= 1'b1;
				end else begin
					total_q <= total_q + 1'b1;
				end
			end

			if (state_q == ST_FLUSH) begin
				total_q <= '0;
				ovf_q   <= 1'b0;
				found_q <= 1'b0;
				addr_q  <= '0;
			end else if (walk_vld_s1 && !found_q && run_sum >= RUN_BITS'(half_q)) begin
				found_q <= 1'b1;
			end

			if (res_vld_q && !res_stall) begin
				res_vld_q <= 1'b0;
			end
			if (state_q == ST_DONE && res_free) begin
				res_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		pix_lvl_s1  <= pixel;
		walk_lvl_s1 <= addr_q;
		wr_lvl_q    <= pix_lvl_s1;
		wr_val_q    <= inc_cnt;
		if (state_q == ST_FLUSH) begin
			half_q      <= total_q >> 1;
			frame_ovf_q <= ovf_q;
			run_q       <= '0;
			median_q    <= '0;
		end else if (walk_vld_s1) begin
			run_q <= run_sum;
			if (!found_q && run_sum >= RUN_BITS'(half_q)) begin
				median_q <= walk_lvl_s1;
			end
		end
		if (state_q == ST_DONE && res_free) begin
			res_level_q <= median_q;
			res_ovf_q   <= frame_ovf_q;
		end
	end

	assign res_valid    = res_vld_q;
	assign median_level = res_level_q;
	assign overflow     = res_ovf_q;

`ifndef ASSERT_OFF
	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		!(pix_vld_s1 && walk_vld_s1))
		else $error("pixel update and walk clear collide on the bin ram");

	a_last_flush: assert property (@(posedge clk) disable iff (!arst_n)
		pix_acc && last_pixel |=> state_q == ST_FLUSH)
		else $error("last pixel transaction did not start the frame flush");

	a_res_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_vld_q) |-> $past(state_q == ST_DONE))
		else $error("result loaded outside the done state");

	a_walk_writes_zero: assert property (@(posedge clk) disable iff (!arst_n)
		walk_vld_s1 |-> ram_we && ram_wdata == '0)
		else $error("walk did not clear the bin it read");

	a_no_pix_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK || state_q == ST_TAIL) |-> !pix_vld_s1)
		else $error("pixel update pending during the walk");
`endif

endmodule
